[rtl/core/ats_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants of the assembly token scanner
// Byte class record, token record, scanner mode and token kind codes.
// ----------------------------------------------------------------------------
package ats_pkg;

	// Default widths and queue size
	localparam int ImmWidthDefault = 32;
	localparam int PosWidthDefault = 32;
	localparam int QueueDepth      = 4;

	// Source bytes with a meaning of their own
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF_A  = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// Scanner modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_ZERO    = 3'd2;
	localparam logic [2:0] MODE_BIN     = 3'd3;
	localparam logic [2:0] MODE_HEX     = 3'd4;
	localparam logic [2:0] MODE_DEC     = 3'd5;
	localparam logic [2:0] MODE_DIR     = 3'd6;
	localparam logic [2:0] MODE_IDENT   = 3'd7;

	// Token kinds
	localparam logic [2:0] KIND_END   = 3'd0;
	localparam logic [2:0] KIND_COLON = 3'd1;
	localparam logic [2:0] KIND_MINUS = 3'd2;
	localparam logic [2:0] KIND_IMM   = 3'd3;
	localparam logic [2:0] KIND_DIR   = 3'd4;
	localparam logic [2:0] KIND_IDENT = 3'd5;
	localparam logic [2:0] KIND_ERROR = 3'd6;

	// Classified source byte
	typedef struct packed {
		logic       is_end;
		logic       is_space;
		logic       is_eol;
		logic       is_semi;
		logic       is_colon;
		logic       is_minus;
		logic       is_dot;
		logic       is_zero;
		logic       is_decimal;
		logic       is_bin;
		logic       is_hex;
		logic       is_alpha;
		logic       is_b;
		logic       is_x;
		logic [3:0] dval;
	} cls_t;

	// One result token as seen on the output port
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [31:0] start;
		logic [15:0] length;
	} tok_t;

	// Sort one byte into the classes the scanner needs
	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		logic dig;
		logic lhex;
		logic uhex;
		dig  = (c >= CH_ZERO) && (c <= CH_NINE);
		lhex = (c >= CH_LA) && (c <= CH_LF_A);
		uhex = (c >= CH_UA) && (c <= CH_UF);
		r.is_end   = (c == CH_NUL);
		r.is_eol   = (c == CH_LF) || (c == CH_CR);
		r.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF) || (c == CH_VT) ||
			(c == CH_LF) || (c == CH_CR);
		r.is_semi  = (c == CH_SEMI);
		r.is_colon = (c == CH_COLON);
		r.is_minus = (c == CH_MINUS);
		r.is_dot   = (c == CH_DOT);
		r.is_zero  = (c == CH_ZERO);
		r.is_decimal = dig;
		r.is_bin   = (c == CH_ZERO) || (c == CH_ONE);
		r.is_hex   = dig || lhex || uhex;
		r.is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			(c == CH_UNDER);
		r.is_b     = (c == CH_LB) || (c == CH_UB);
		r.is_x     = (c == CH_LX) || (c == CH_UX);
		// letters a-f and A-F have low nibble 1..6, worth 10..15
		r.dval     = dig ? c[3:0] : (c[3:0] + 4'd9);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/ats_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ats_front: byte intake
// Accepts source bytes, classifies them and tags each with its offset.
// ----------------------------------------------------------------------------
module ats_front #(
	parameter int POS_WIDTH = ats_pkg::PosWidthDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  src_valid,
	output logic                 src_ready,
	input  wire  [7:0]           ch,
	output logic                 push_valid,
	input  wire                  push_ready,
	output ats_pkg::cls_t        push_cls,
	output logic [POS_WIDTH-1:0] push_pos
);
	import ats_pkg::*;

	logic [POS_WIDTH-1:0] pos_q;
	logic                 take;

	assign src_ready  = push_ready;
	assign push_valid = src_valid;
	assign push_cls   = classify(ch);
	assign push_pos   = pos_q;
	assign take       = src_valid && push_ready;

	// Offset of the next byte: saturates, back to zero after end of input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (ch == CH_NUL) begin
				pos_q <= '0;
			end else if (pos_q != {POS_WIDTH{1'b1}}) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/ats_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ats_queue: small FIFO between intake and scanner
// Register-based ring buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ats_queue #(
	parameter int DEPTH = ats_pkg::QueueDepth,
	parameter int WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import ats_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[head_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[tail_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop_fire) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill level beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill level missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !push_fire |=> count_q == $past(count_q) - 1'b1)
		else $error("queue fill level missed a pop");

endmodule
`default_nettype wire

[rtl/core/ats_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ats_scan: token scanner back end
// Steps the scan state by one classified byte per cycle when the output
// has room, and hands out the zero, one or two tokens it causes through
// an output register and a one-entry holding register for the second token.
// ----------------------------------------------------------------------------
module ats_scan #(
	parameter int IMM_WIDTH = ats_pkg::ImmWidthDefault,
	parameter int POS_WIDTH = ats_pkg::PosWidthDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  hd_valid,
	output logic                 hd_ready,
	input  ats_pkg::cls_t        hd_cls,
	input  wire  [POS_WIDTH-1:0] hd_pos,
	output logic                 tok_valid,
	input  wire                  tok_ready,
	output ats_pkg::tok_t        tok,
	output logic                 tok_last
);
	import ats_pkg::*;

	// Scan state
	logic [2:0]           mode_q;
	logic [IMM_WIDTH-1:0] acc_q;
	logic [POS_WIDTH-1:0] start_q;
	logic [15:0]          run_q;

	// Output register and holding register
	logic out_v_q;
	tok_t out_q;
	logic out_last_q;
	logic pend_v_q;
	tok_t pend_q;

	// Next-state and token terms
	logic [2:0]           mode_d;
	logic [IMM_WIDTH-1:0] acc_d;
	logic [POS_WIDTH-1:0] start_d;
	logic [15:0]          run_d;
	logic [15:0]          run_inc;
	logic [IMM_WIDTH-1:0] dv;
	logic                 took;
	logic                 close_v;
	logic [2:0]           close_kind;
	logic                 beg_v;
	logic [2:0]           beg_kind;
	logic [15:0]          beg_len;
	logic [63:0]          acc_ext;
	logic [63:0]          start_ext;
	logic [63:0]          pos_ext;
	tok_t                 close_tok;
	tok_t                 beg_tok;
	logic                 pop;

	assign run_inc   = (run_q == 16'hFFFF) ? run_q : run_q + 16'd1;
	assign dv        = IMM_WIDTH'(hd_cls.dval);
	assign acc_ext   = 64'(acc_q);
	assign start_ext = 64'(start_q);
	assign pos_ext   = 64'(hd_pos);

	// One scan step for the byte at the head of the queue
	always_comb begin
		mode_d     = mode_q;
		acc_d      = acc_q;
		start_d    = start_q;
		run_d      = run_q;
		took       = 1'b0;
		close_v    = 1'b0;
		close_kind = KIND_IMM;
		beg_v      = 1'b0;
		beg_kind   = KIND_END;
		beg_len    = 16'd1;

		case (mode_q)
			MODE_COMMENT: begin
				if (hd_cls.is_eol || hd_cls.is_end) begin
					mode_d = MODE_IDLE;
				end else begin
					took = 1'b1;
				end
			end
			MODE_ZERO: begin
				if (hd_cls.is_b) begin
					mode_d = MODE_BIN;
					run_d  = run_inc;
					took   = 1'b1;
				end else if (hd_cls.is_x) begin
					mode_d = MODE_HEX;
					run_d  = run_inc;
					took   = 1'b1;
				end else if (hd_cls.is_decimal) begin
					mode_d = MODE_DEC;
					acc_d  = dv;
					run_d  = run_inc;
					took   = 1'b1;
				end else begin
					close_v = 1'b1;
				end
			end
			MODE_BIN: begin
				if (hd_cls.is_bin) begin
					acc_d = (acc_q << 1) + dv;
					run_d = run_inc;
					took  = 1'b1;
				end else begin
					close_v = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hd_cls.is_hex) begin
					acc_d = (acc_q << 4) + dv;
					run_d = run_inc;
					took  = 1'b1;
				end else begin
					close_v = 1'b1;
				end
			end
			MODE_DEC: begin
				// times ten as two shifted copies
				if (hd_cls.is_decimal) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + dv;
					run_d = run_inc;
					took  = 1'b1;
				end else begin
					close_v = 1'b1;
				end
			end
			MODE_DIR, MODE_IDENT: begin
				if (hd_cls.is_alpha || hd_cls.is_decimal) begin
					run_d = run_inc;
					took  = 1'b1;
				end else begin
					close_v    = 1'b1;
					close_kind = (mode_q == MODE_DIR) ? KIND_DIR : KIND_IDENT;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		// Byte not absorbed: it is skipped or opens something new
		if (!took) begin
			mode_d = MODE_IDLE;
			if (hd_cls.is_end) begin
				beg_v    = 1'b1;
				beg_kind = KIND_END;
				beg_len  = 16'd0;
				acc_d    = '0;
				start_d  = '0;
				run_d    = 16'd0;
			end else if (hd_cls.is_space) begin
				mode_d = MODE_IDLE;
			end else if (hd_cls.is_semi) begin
				mode_d = MODE_COMMENT;
			end else if (hd_cls.is_colon) begin
				beg_v    = 1'b1;
				beg_kind = KIND_COLON;
			end else if (hd_cls.is_minus) begin
				beg_v    = 1'b1;
				beg_kind = KIND_MINUS;
			end else if (hd_cls.is_decimal) begin
				mode_d  = hd_cls.is_zero ? MODE_ZERO : MODE_DEC;
				start_d = hd_pos;
				run_d   = 16'd1;
				acc_d   = dv;
			end else if (hd_cls.is_dot || hd_cls.is_alpha) begin
				mode_d  = hd_cls.is_dot ? MODE_DIR : MODE_IDENT;
				start_d = hd_pos;
				run_d   = 16'd1;
				acc_d   = '0;
			end else begin
				beg_v    = 1'b1;
				beg_kind = KIND_ERROR;
			end
		end
	end

	// Token records with saturated offsets
	always_comb begin
		close_tok.kind   = close_kind;
		close_tok.value  = (close_kind == KIND_IMM) ? acc_ext[31:0] : 32'd0;
		close_tok.start  = (start_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF :
			start_ext[31:0];
		close_tok.length = run_q;
		beg_tok.kind     = beg_kind;
		beg_tok.value    = 32'd0;
		beg_tok.start    = (pos_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF :
			pos_ext[31:0];
		beg_tok.length   = beg_len;
	end

	// Take the head byte when all its tokens have a place to go
	assign pop      = hd_valid && !pend_v_q &&
		(!out_v_q || tok_ready || !(close_v || beg_v));
	assign hd_ready = pop;

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			start_q <= '0;
			run_q   <= '0;
		end else if (pop) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			start_q <= start_d;
			run_q   <= run_d;
		end
	end

	// Output and holding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (pop && (close_v || beg_v)) begin
			out_v_q  <= 1'b1;
			pend_v_q <= close_v && beg_v;
		end else if (out_v_q && tok_ready) begin
			out_v_q  <= pend_v_q;
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (close_v || beg_v)) begin
			out_q      <= close_v ? close_tok : beg_tok;
			out_last_q <= !(close_v && beg_v);
			pend_q     <= beg_tok;
		end else if (out_v_q && tok_ready && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign tok_valid = out_v_q;
	assign tok       = out_q;
	assign tok_last  = out_last_q;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_v_q && !out_last_q)
		else $error("held token without a first token in front");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.kind == KIND_END |-> out_last_q && out_q.length == 16'd0)
		else $error("end token not last or with nonzero length");

	a_no_pop_on_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> !pop)
		else $error("byte taken while a second token is held");

endmodule
`default_nettype wire

[rtl/core/assembly_token_scanner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// assembly_token_scanner: streaming lexer for assembly source
// Takes one source byte per item and returns tokens with kind, immediate
// value, start offset and length.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------------
//   source  | src_valid, src_ready, ch                  | one byte, 0 = end
//   tokens  | tok_valid, tok_ready, token_kind,         | one token, last marks
//           | imm_value, token_start, token_length, last| the byte's final one
//
// A byte enters the intake queue in the cycle it is accepted and is scanned
// from its head; its first token is registered and shown in the cycle after.
// The scanner takes one byte per cycle while the output has room; a byte
// that ends one token and emits another holds back the next byte until
// its second token leaves the holding register. The four-entry queue lets
// intake continue while the output stalls. Reset is asynchronous and clears
// the queue, the scan state and the output register; no clearing pass.
// ----------------------------------------------------------------------------
module assembly_token_scanner #(
	parameter int IMM_WIDTH = ats_pkg::ImmWidthDefault,
	parameter int POS_WIDTH = ats_pkg::PosWidthDefault
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         src_valid,
	output logic        src_ready,
	input  wire  [7:0]  ch,
	output logic        tok_valid,
	input  wire         tok_ready,
	output logic [2:0]  token_kind,
	output logic [31:0] imm_value,
	output logic [31:0] token_start,
	output logic [15:0] token_length,
	output logic        last
);
	import ats_pkg::*;

	localparam int ItemW = $bits(cls_t) + POS_WIDTH;

	logic                 push_valid;
	logic                 push_ready;
	cls_t                 push_cls;
	logic [POS_WIDTH-1:0] push_pos;
	logic                 hd_valid;
	logic                 hd_ready;
	logic [ItemW-1:0]     hd_data;
	cls_t                 hd_cls;
	logic [POS_WIDTH-1:0] hd_pos;
	tok_t                 tok;

	// Intake and classification
	ats_front #(
		.POS_WIDTH(POS_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.ch        (ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cls  (push_cls),
		.push_pos  (push_pos)
	);

	// Decoupling queue
	ats_queue #(
		.DEPTH(QueueDepth),
		.WIDTH(ItemW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_cls, push_pos}),
		.pop_valid (hd_valid),
		.pop_ready (hd_ready),
		.pop_data  (hd_data)
	);

	assign hd_cls = hd_data[ItemW-1:POS_WIDTH];
	assign hd_pos = hd_data[POS_WIDTH-1:0];

	// Scanner and output stage
	ats_scan #(
		.IMM_WIDTH(IMM_WIDTH),
		.POS_WIDTH(POS_WIDTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (hd_valid),
		.hd_ready (hd_ready),
		.hd_cls   (hd_cls),
		.hd_pos   (hd_pos),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok      (tok),
		.tok_last (last)
	);

	assign token_kind   = tok.kind;
	assign imm_value    = tok.value;
	assign token_start  = tok.start;
	assign token_length = tok.length;

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the assembly token scanner
// Streams source bytes into the scanner and checks every token it returns
// against a cycle-free model of the lexer kept inside the bench. Both the
// byte source and the token sink idle at random, and the sink holds off
// once for a long stretch so that the intake queue fills up.
// ----------------------------------------------------------------------------
module tb;

	import ats_pkg::*;

	localparam int LimitCycles = 2_000_000;
	localparam int RandomBytes = 2000;
	localparam int LongIdent   = 100;

	// One token as predicted, with its last flag
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [31:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	// One pending source byte; tight bytes are followed by no gap
	typedef struct packed {
		logic [7:0] ch;
		logic       tight;
	} source_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	logic [7:0]  ch = CH_NUL;
	logic        tok_valid;
	logic        tok_ready = 1'b0;
	logic [2:0]  token_kind;
	logic [31:0] imm_value;
	logic [31:0] token_start;
	logic [15:0] token_length;
	logic        last;

	source_item_t source_items[$];
	source_item_t next_item;
	token_t       tokens_due[$];
	token_t       byte_tokens[$];
	token_t       want;

	// Lexer state mirrored from the block
	logic [2:0]  scan_mode = MODE_IDLE;
	logic [31:0] accum = '0;
	logic [31:0] position = '0;
	logic [31:0] start_off = '0;
	logic [15:0] run_len = '0;

	int mismatches = 0;
	int tokens_seen = 0;
	int cycles = 0;
	int src_gap = 0;
	int src_calm = 0;
	int stall_left = 0;
	int snk_calm = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	assembly_token_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.ch(ch),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.token_kind(token_kind),
		.imm_value(imm_value),
		.token_start(token_start),
		.token_length(token_length),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Byte classes
	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT ||
			c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic is_decimal(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_word_start(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
	endfunction

	// Hex digit value, -1 when c is no hex digit
	function automatic int hex_digit(input logic [7:0] c);
		if (is_decimal(c))
			return c - CH_ZERO;
		if (c >= CH_LA && c <= CH_LF_A)
			return c - CH_LA + 10;
		if (c >= CH_UA && c <= CH_UF)
			return c - CH_UA + 10;
		return -1;
	endfunction

	task automatic emit_token(input logic [2:0] kind, input logic [31:0] value,
			input logic [31:0] start, input logic [15:0] length);
		token_t t;
		t.kind = kind;
		t.value = value;
		t.start = start;
		t.length = length;
		t.last = 1'b0;
		byte_tokens.push_back(t);
	endtask

	task automatic close_pending(input logic [2:0] kind);
		emit_token(kind, (kind == KIND_IMM) ? accum : 32'd0, start_off, run_len);
		scan_mode = MODE_IDLE;
	endtask

	task automatic start_token(input logic [2:0] mode, input logic [31:0] first);
		scan_mode = mode;
		start_off = position;
		run_len = 16'd1;
		accum = first;
	endtask

	task automatic grow_run();
		if (run_len != 16'hFFFF)
			run_len++;
	endtask

	// Byte seen with no token open
	task automatic scan_idle(input logic [7:0] c);
		scan_mode = MODE_IDLE;
		if (c == CH_NUL) begin
			emit_token(KIND_END, 32'd0, position, 16'd0);
			position = '0;
			accum = '0;
			start_off = '0;
			run_len = '0;
		end else if (is_blank(c)) begin
			// skipped
		end else if (c == CH_SEMI) begin
			scan_mode = MODE_COMMENT;
		end else if (c == CH_COLON) begin
			emit_token(KIND_COLON, 32'd0, position, 16'd1);
		end else if (c == CH_MINUS) begin
			emit_token(KIND_MINUS, 32'd0, position, 16'd1);
		end else if (c == CH_ZERO) begin
			start_token(MODE_ZERO, 32'd0);
		end else if (is_decimal(c)) begin
			start_token(MODE_DEC, {28'd0, c[3:0]});
		end else if (c == CH_DOT) begin
			start_token(MODE_DIR, 32'd0);
		end else if (is_word_start(c)) begin
			start_token(MODE_IDENT, 32'd0);
		end else begin
			emit_token(KIND_ERROR, 32'd0, position, 16'd1);
		end
	endtask

	// Advance the lexer by one accepted byte and queue the tokens it yields
	task automatic scan_byte(input logic [7:0] c);
		logic took;
		int hv;
		took = 1'b0;
		byte_tokens.delete();
		case (scan_mode)
			MODE_COMMENT: begin
				if (c == CH_LF || c == CH_CR || c == CH_NUL)
					scan_mode = MODE_IDLE;
				else
					took = 1'b1;
			end
			MODE_ZERO: begin
				if (c == CH_LB || c == CH_UB) begin
					scan_mode = MODE_BIN;
					grow_run();
					took = 1'b1;
				end else if (c == CH_LX || c == CH_UX) begin
					scan_mode = MODE_HEX;
					grow_run();
					took = 1'b1;
				end else if (is_decimal(c)) begin
					scan_mode = MODE_DEC;
					accum = {28'd0, c[3:0]};
					grow_run();
					took = 1'b1;
				end else begin
					close_pending(KIND_IMM);
				end
			end
			MODE_BIN: begin
				if (c == CH_ZERO || c == CH_ONE) begin
					accum = {accum[30:0], c[0]};
					grow_run();
					took = 1'b1;
				end else begin
					close_pending(KIND_IMM);
				end
			end
			MODE_HEX: begin
				hv = hex_digit(c);
				if (hv >= 0) begin
					accum = {accum[27:0], 4'(hv)};
					grow_run();
					took = 1'b1;
				end else begin
					close_pending(KIND_IMM);
				end
			end
			MODE_DEC: begin
				if (is_decimal(c)) begin
					accum = accum * 32'd10 + {28'd0, c[3:0]};
					grow_run();
					took = 1'b1;
				end else begin
					close_pending(KIND_IMM);
				end
			end
			MODE_DIR, MODE_IDENT: begin
				if (is_word_start(c) || is_decimal(c)) begin
					grow_run();
					took = 1'b1;
				end else begin
					close_pending((scan_mode == MODE_DIR) ? KIND_DIR : KIND_IDENT);
				end
			end
			default: scan_mode = MODE_IDLE;
		endcase
		if (!took)
			scan_idle(c);
		if (c != CH_NUL && position != '1)
			position++;
		if (byte_tokens.size() != 0)
			byte_tokens[byte_tokens.size() - 1].last = 1'b1;
		foreach (byte_tokens[i])
			tokens_due.push_back(byte_tokens[i]);
	endtask

	// Stimulus helpers
	task automatic add_byte(input logic [7:0] b, input logic tight = 1'b0);
		source_item_t s;
		s.ch = b;
		s.tight = tight;
		source_items.push_back(s);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] word_char();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'(CH_LA + r);
		if (r < 52)
			return 8'(CH_UA + r - 26);
		if (r < 62)
			return 8'(CH_ZERO + r - 52);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return 8'(CH_ZERO + r);
		if (r < 16)
			return 8'(CH_LA + r - 10);
		return 8'(CH_UA + r - 16);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_FF;
			3: return CH_VT;
			4: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// One random token, mostly well formed, then maybe some blanks
	task automatic add_random_token();
		int r;
		int n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 16) begin
			add_byte(8'(CH_ONE + $urandom_range(0, 8)));
			n = $urandom_range(0, 11);
			repeat (n) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (r < 30) begin
			add_byte(CH_ZERO);
			add_byte($urandom_range(0, 1) ? CH_LX : CH_UX);
			n = $urandom_range(0, 10);
			repeat (n) add_byte(hex_char());
		end else if (r < 40) begin
			add_byte(CH_ZERO);
			add_byte($urandom_range(0, 1) ? CH_LB : CH_UB);
			n = $urandom_range(0, 40);
			repeat (n) add_byte(8'(CH_ZERO + $urandom_range(0, 1)));
		end else if (r < 46) begin
			// lone zero, or decimal with leading zeros
			add_byte(CH_ZERO);
			n = $urandom_range(0, 3);
			repeat (n) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (r < 62) begin
			do b = word_char(); while (is_decimal(b));
			add_byte(b);
			n = $urandom_range(0, 12);
			repeat (n) add_byte(word_char());
		end else if (r < 72) begin
			add_byte(CH_DOT);
			n = $urandom_range(0, 10);
			repeat (n) add_byte(word_char());
		end else if (r < 78) begin
			add_byte($urandom_range(0, 1) ? CH_COLON : CH_MINUS);
		end else if (r < 86) begin
			add_byte(CH_SEMI);
			n = $urandom_range(0, 20);
			repeat (n) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == CH_CR);
				add_byte(b);
			end
			r = $urandom_range(0, 9);
			add_byte((r == 0) ? CH_NUL : (r < 6) ? CH_LF : CH_CR);
		end else if (r < 95) begin
			add_byte(8'($urandom_range(1, 255)));
		end else begin
			add_byte(CH_NUL);
		end
		if ($urandom_range(0, 1)) begin
			n = $urandom_range(1, 3);
			repeat (n) add_byte(blank_char());
		end
	endtask

	// Idle length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	// Report one field; counts the mismatch
	task automatic check_field(input string what, input logic [31:0] expected,
			input logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, expected, actual);
			mismatches++;
		end
	endtask

	// Source driver: one item per handshake, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			ch <= CH_NUL;
		end else if (!src_valid || src_ready) begin
			if (src_valid)
				scan_byte(ch);
			if (src_gap != 0) begin
				src_gap--;
				src_valid <= 1'b0;
			end else if (source_items.size() != 0) begin
				next_item = source_items.pop_front();
				ch <= next_item.ch;
				src_valid <= 1'b1;
				if (next_item.tight || src_calm != 0)
					src_gap = 0;
				else if ($urandom_range(0, 3) == 0)
					src_gap = idle_len();
				else
					src_gap = 0;
				if (src_calm != 0)
					src_calm--;
				else if ($urandom_range(0, 99) == 0)
					src_calm = $urandom_range(30, 150);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Token sink: checks each accepted item, stalls at random, holds off once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ready <= 1'b0;
		end else begin
			if (tok_valid && tok_ready) begin
				tokens_seen++;
				if (tokens_due.size() == 0) begin
					$display("%0t: token expected none actual kind %0d start %0d",
						$time, token_kind, token_start);
					mismatches++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", 32'(want.kind), 32'(token_kind));
					check_field("imm_value", want.value, imm_value);
					check_field("token_start", want.start, token_start);
					check_field("token_length", 32'(want.length), 32'(token_length));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				tok_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= 1'b1;
				if (!hold_done && tokens_seen >= 150) begin
					hold_done = 1'b1;
					hold_left = 400;
				end else if (snk_calm != 0) begin
					snk_calm--;
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = idle_len();
				end else if ($urandom_range(0, 99) == 0) begin
					snk_calm = $urandom_range(30, 150);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LimitCycles) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// every token kind, both prefix cases, bare prefix, two tokens from one byte
		add_text(":-0b1 0XaF 9;c\n0x.d _z");
		add_byte(8'h80);
		add_byte(8'hFF);
		add_text("!");
		add_byte(CH_NUL);
		// lone zero, comment ended by CR, end inside a comment
		add_text("0- id;x");
		add_byte(CH_CR);
		add_text(";y");
		add_byte(CH_NUL);
		// end inside a token
		add_text("12");
		add_byte(CH_NUL);

		while (source_items.size() < RandomBytes + 40)
			add_random_token();

		// long identifier sent back to back
		add_byte(CH_SPACE);
		add_byte(CH_UNDER, 1'b1);
		repeat (LongIdent - 1) add_byte(word_char(), 1'b1);
		add_byte(CH_NUL);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (source_items.size() != 0 || src_valid)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
rtl/core/ats_pkg.sv
rtl/core/ats_front.sv
rtl/core/ats_queue.sv
rtl/core/ats_scan.sv
rtl/core/assembly_token_scanner.sv
sim/tb.sv
